[sv/vfc_pkg.sv]
// Package for the voxel face cull and AO block: widths, face tables and
// the per-face sampling functions. No dependencies.
package vfc_pkg;

  localparam int CHUNK_SIZE = 32;
  localparam int COORD_W    = 5;
  localparam int NB_W       = 27;
  localparam int DIR_W      = 3;
  localparam int AO_W       = 8;
  localparam int UV_W       = 8;
  localparam int VTX_W      = 20;
  localparam int NUM_FACES  = 6;
  localparam int NUM_VERTS  = 4;
  localparam int CENTER_BIT = 13;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [2:0][COORD_W-1:0] pos_t;
  typedef logic [NB_W-1:0] nbhd_t;
  typedef logic [NUM_FACES-1:0] face_mask_t;
  typedef logic [NUM_FACES-1:0][AO_W-1:0] face_ao_t;

  typedef enum logic [DIR_W-1:0] {
    FACE_ZN = 3'd0,
    FACE_ZP = 3'd1,
    FACE_XN = 3'd2,
    FACE_XP = 3'd3,
    FACE_YN = 3'd4,
    FACE_YP = 3'd5
  } face_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  // cube corner per face vertex: bit0 x, bit1 y, bit2 z
  localparam logic [2:0] FACE_CORNER [NUM_FACES][NUM_VERTS] = '{
    '{3'd0, 3'd2, 3'd3, 3'd1},
    '{3'd4, 3'd5, 3'd7, 3'd6},
    '{3'd0, 3'd4, 3'd6, 3'd2},
    '{3'd1, 3'd3, 3'd7, 3'd5},
    '{3'd0, 3'd1, 3'd5, 3'd4},
    '{3'd2, 3'd6, 3'd7, 3'd3}
  };

  // normal axis per face pair: 0 x, 1 y, 2 z
  localparam int FACE_AXIS [3] = '{2, 0, 1};

  localparam logic [NUM_VERTS-1:0] BASE_U = 4'b0110;
  localparam logic [NUM_VERTS-1:0] BASE_V = 4'b1100;

  function automatic logic outside(coord_t c, int d);
    int p;
    p = int'(c) + d;
    return (p < 0) || (p >= CHUNK_SIZE);
  endfunction

  // occupancy of one neighbor; cells past two chunk boundaries read empty
  function automatic logic sample(pos_t pos, nbhd_t nb, int off [3]);
    int crossings;
    int idx;
    crossings = int'(outside(pos[0], off[0])) + int'(outside(pos[1], off[1]))
              + int'(outside(pos[2], off[2]));
    idx = (off[2] + 1) * 9 + (off[1] + 1) * 3 + (off[0] + 1);
    if (crossings >= 2) begin
      return 1'b0;
    end
    return nb[5'(idx)];
  endfunction

  function automatic logic face_visible(pos_t pos, nbhd_t nb, int f);
    int n [3];
    n = '{0, 0, 0};
    n[FACE_AXIS[f >> 1]] = ((f & 1) != 0) ? 1 : -1;
    return nb[CENTER_BIT] && !sample(pos, nb, n);
  endfunction

  function automatic logic [AO_W-1:0] face_ao(pos_t pos, nbhd_t nb, int f);
    int axis;
    int a1;
    int a2;
    int s1;
    int s2;
    int n [3];
    int o1 [3];
    int o2 [3];
    int oc [3];
    logic [2:0] c;
    logic [1:0] solid;
    logic [AO_W-1:0] ao;
    axis = FACE_AXIS[f >> 1];
    a1 = (axis == 0) ? 1 : 0;
    a2 = (axis == 2) ? 1 : 2;
    n = '{0, 0, 0};
    n[axis] = ((f & 1) != 0) ? 1 : -1;
    ao = '0;
    for (int k = 0; k < NUM_VERTS; k++) begin
      c = FACE_CORNER[f][k];
      s1 = c[a1] ? 1 : -1;
      s2 = c[a2] ? 1 : -1;
      o1 = n;
      o2 = n;
      oc = n;
      o1[a1] = s1;
      o2[a2] = s2;
      oc[a1] = s1;
      oc[a2] = s2;
      solid = 2'(sample(pos, nb, o1)) + 2'(sample(pos, nb, o2))
            + 2'(sample(pos, nb, oc));
      ao[2*k +: 2] = 2'd3 - solid;
    end
    return ao;
  endfunction

  function automatic logic [UV_W-1:0] uv_corners(logic [1:0] rot, logic flip);
    logic u;
    logic v;
    logic tu;
    logic tv;
    logic [UV_W-1:0] uv;
    uv = '0;
    for (int k = 0; k < NUM_VERTS; k++) begin
      u = BASE_U[k];
      v = BASE_V[k];
      unique case (rot_e'(rot))
        ROT_90: begin
          tu = ~v;
          tv = u;
        end
        ROT_180: begin
          tu = ~u;
          tv = ~v;
        end
        ROT_270: begin
          tu = v;
          tv = ~u;
        end
        default: begin
          tu = u;
          tv = v;
        end
      endcase
      uv[2*k]     = tu ^ flip;
      uv[2*k + 1] = tv;
    end
    return uv;
  endfunction

endpackage

[sv/vfc_if.sv]
// Valid/ready channel interfaces for voxel words in and face words out.
// Depends on vfc_pkg.
interface vfc_in_if;
  logic                   valid;
  logic                   ready;
  vfc_pkg::coord_t        voxel_x;
  vfc_pkg::coord_t        voxel_y;
  vfc_pkg::coord_t        voxel_z;
  vfc_pkg::nbhd_t         neighborhood;
  logic [1:0]             rotation;
  logic                   flip;
  logic                   chunk_start;

  modport source (
    output valid, voxel_x, voxel_y, voxel_z, neighborhood, rotation, flip,
           chunk_start,
    input  ready
  );
  modport sink (
    input  valid, voxel_x, voxel_y, voxel_z, neighborhood, rotation, flip,
           chunk_start,
    output ready
  );
endinterface

interface vfc_out_if;
  logic                          valid;
  logic                          ready;
  vfc_pkg::coord_t               face_x;
  vfc_pkg::coord_t               face_y;
  vfc_pkg::coord_t               face_z;
  logic [vfc_pkg::DIR_W-1:0]     face_dir;
  logic [vfc_pkg::AO_W-1:0]      ao_corners;
  logic [vfc_pkg::UV_W-1:0]      uv_corners;
  logic [vfc_pkg::VTX_W-1:0]     first_vertex;
  logic                          last_face;

  modport source (
    output valid, face_x, face_y, face_z, face_dir, ao_corners, uv_corners,
           first_vertex, last_face,
    input  ready
  );
  modport sink (
    input  valid, face_x, face_y, face_z, face_dir, ao_corners, uv_corners,
           first_vertex, last_face,
    output ready
  );
endinterface

[sv/vfc_face_eval.sv]
// Face visibility, per-face AO levels and corner UVs for one held voxel.
// Depends on vfc_pkg.
module vfc_face_eval (
  input  vfc_pkg::pos_t                   pos_i,
  input  vfc_pkg::nbhd_t                  nb_i,
  input  logic [1:0]                      rotation_i,
  input  logic                            flip_i,
  output vfc_pkg::face_mask_t             visible_o,
  output vfc_pkg::face_ao_t               ao_o,
  output logic [vfc_pkg::UV_W-1:0]        uv_o
);
  import vfc_pkg::*;

  for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
    assign visible_o[f] = face_visible(pos_i, nb_i, f);
    assign ao_o[f]      = face_ao(pos_i, nb_i, f);
  end

  assign uv_o = uv_corners(rotation_i, flip_i);

endmodule

[sv/voxel_face_cull_ao.sv]
// Top level: voxel word register, face picker, vertex counter, face word
// register. Depends on vfc_pkg, vfc_if and vfc_face_eval.
//
//   channel  | dir | word
//   ---------+-----+-----------------------------------------------
//   vox_i    | in  | voxel position, 3x3x3 occupancy, rotation, flip
//   face_o   | out | one visible face with AO, UVs, first vertex
//
// A voxel word holds the voxel register until all its visible faces are picked;
// the single face word register sets one face per cycle unless face_o stalls.
// The next voxel is taken in the cycle its predecessor's last face is picked.
// Reset clears the valid flags, the done mask and the vertex counter.
// A stall on face_o holds the face word and backs up into vox_i.ready.
module voxel_face_cull_ao (
  input  logic          clk_i,
  input  logic          rst_ni,
  vfc_in_if.sink        vox_i,
  vfc_out_if.source     face_o
);
  import vfc_pkg::*;

  logic                  item_vld_q;
  pos_t                  pos_q;
  nbhd_t                 nb_q;
  logic [1:0]            rot_q;
  logic                  flip_q;
  face_mask_t            done_q;
  face_mask_t            done_d;
  logic [VTX_W-1:0]      vcnt_q;
  logic [VTX_W-1:0]      vcnt_d;
  logic                  out_vld_q;

  face_mask_t            visible;
  face_ao_t              ao;
  logic [UV_W-1:0]       uv;
  face_mask_t            remaining;
  face_mask_t            sel_hot;
  logic [DIR_W-1:0]      sel_idx;
  logic                  sel_found;
  logic                  last;
  logic                  out_free;
  logic                  emit;
  logic                  item_done;
  logic                  load;

  vfc_face_eval u_eval (
    .pos_i      (pos_q),
    .nb_i       (nb_q),
    .rotation_i (rot_q),
    .flip_i     (flip_q),
    .visible_o  (visible),
    .ao_o       (ao),
    .uv_o       (uv)
  );

  assign remaining = item_vld_q ? (visible & ~done_q) : '0;

  always_comb begin
    sel_hot   = '0;
    sel_idx   = DIR_W'(FACE_ZN);
    sel_found = 1'b0;
    for (int f = 0; f < NUM_FACES; f++) begin
      if (remaining[f] && !sel_found) begin
        sel_hot[f] = 1'b1;
        sel_idx    = DIR_W'(f);
        sel_found  = 1'b1;
      end
    end
  end

  assign last      = (remaining & ~sel_hot) == '0;
  assign out_free  = !out_vld_q || face_o.ready;
  assign emit      = sel_found && out_free;
  assign item_done = item_vld_q && (!sel_found || (emit && last));
  assign vox_i.ready = !item_vld_q || item_done;
  assign load      = vox_i.valid && vox_i.ready;

  always_comb begin
    done_d = done_q;
    if (load) begin
      done_d = '0;
    end else if (emit) begin
      done_d = done_q | sel_hot;
    end
  end

  // chunk start clears after the previous voxel's final face took its index
  always_comb begin
    vcnt_d = vcnt_q;
    if (load && vox_i.chunk_start) begin
      vcnt_d = '0;
    end else if (emit) begin
      vcnt_d = vcnt_q + VTX_W'(NUM_VERTS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      done_q     <= '0;
      vcnt_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (load) begin
        item_vld_q <= 1'b1;
      end else if (item_done) begin
        item_vld_q <= 1'b0;
      end
      done_q <= done_d;
      vcnt_q <= vcnt_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (face_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pos_q  <= {vox_i.voxel_z, vox_i.voxel_y, vox_i.voxel_x};
      nb_q   <= vox_i.neighborhood;
      rot_q  <= vox_i.rotation;
      flip_q <= vox_i.flip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      face_o.face_x       <= pos_q[0];
      face_o.face_y       <= pos_q[1];
      face_o.face_z       <= pos_q[2];
      face_o.face_dir     <= sel_idx;
      face_o.ao_corners   <= ao[sel_idx];
      face_o.uv_corners   <= uv;
      face_o.first_vertex <= vcnt_q;
      face_o.last_face    <= last;
    end
  end

  assign face_o.valid = out_vld_q;

endmodule
